>>> rtl/lir_pkg.sv
// Shared types, constants and helpers for the linear interpolation resampler.
package lir_pkg;

  localparam int unsigned MAX_SAMPLE_LENGTH_DEF = 65534;

  localparam int PERIOD_W = 10;
  localparam int LEN_W    = 16;
  localparam int IDX_W    = 17;
  localparam int WL_W     = 20;
  localparam int DVD_W    = 48;
  localparam int FRAC_W   = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 10'd113;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 10'd907;

  localparam logic [4:0] BURST_CAP = 5'd24;

  typedef enum logic [1:0] {
    REG_REF_PERIOD    = 2'd0,
    REG_NEW_PERIOD    = 2'd1,
    REG_SOURCE_LENGTH = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [WL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
    logic [PERIOD_W-1:0] r;
    if (p < PERIOD_MIN) r = PERIOD_MIN;
    else if (p > PERIOD_MAX) r = PERIOD_MAX;
    else r = p;
    return r;
  endfunction

endpackage

>>> rtl/lir_div.sv
// Shared iterative restoring divider, one quotient bit per cycle.
module lir_div (
  input  logic              clk,
  input  logic              rst,
  input  lir_pkg::div_req_t req,
  output lir_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(lir_pkg::DVD_W + 1);

  logic [lir_pkg::DVD_W-1:0] dvd;
  logic [lir_pkg::WL_W-1:0]  divisor;
  logic [lir_pkg::WL_W-1:0]  rem;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;

  logic [lir_pkg::WL_W:0]    trial;
  logic                      q_bit;
  logic [lir_pkg::WL_W:0]    diff;

  assign trial = {rem, dvd[lir_pkg::DVD_W-1]};
  assign q_bit = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dvd     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
        cnt     <= CNT_W'(lir_pkg::DVD_W);
        busy    <= 1'b1;
      end else if (busy) begin
        dvd <= {dvd[lir_pkg::DVD_W-2:0], q_bit};
        rem <= q_bit ? diff[lir_pkg::WL_W-1:0] : trial[lir_pkg::WL_W-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

>>> rtl/lir_interp.sv
// Linear interpolation of two signed samples by a 16-bit fraction.
module lir_interp (
  input  logic signed [7:0] s1,
  input  logic signed [7:0] s2,
  input  logic [15:0]       frac,
  output logic signed [7:0] y
);

  logic signed [8:0]  diff;
  logic signed [25:0] prod;
  logic signed [17:0] prod_sh;
  logic signed [17:0] acc;

  assign diff    = 9'(s2) - 9'(s1);
  assign prod    = 26'(diff) * $signed({10'b0, frac});
  assign prod_sh = 18'(prod >>> 8);
  assign acc     = $signed({{2{s1[7]}}, s1, 8'b0}) + prod_sh;
  assign y       = acc[15:8];

endmodule

>>> rtl/linear_interp_resampler.sv
// Linear interpolation resampler top level: sequencer, run state and output register.
// Takes one signed 8-bit source sample per request and emits the resampled stream,
// run_last on tlast marking the final output of a run. The first request of a run forms
// len*new_period in ST_START, then uses the shared divider for the output length and,
// unless the run passes samples through, once more for the 16.32 step. After that each
// request produces its outputs (the burst is capped at 24), with one output per cycle
// while the output side keeps taking them. A pass-through request forwards its sample.
// Register writes are taken only while the block is idle and no request is offered;
// writes to the three period and length registers abort the current run, and the next
// request starts a new one.
module linear_interp_resampler #(
  parameter int unsigned MAX_SAMPLE_LENGTH = lir_pkg::MAX_SAMPLE_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] sample_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,     // [7:0] sample_out
  output logic        m_tlast,     // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_SAMPLE_LENGTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV1,
    ST_DIV2,
    ST_EMIT
  } state_t;

  state_t state;

  logic [lir_pkg::PERIOD_W-1:0] ref_period;
  logic [lir_pkg::PERIOD_W-1:0] new_period;
  logic [lir_pkg::LEN_W-1:0]    source_length;
  logic signed [7:0]            prev_sample;
  logic signed [7:0]            cur_sample;
  logic [lir_pkg::DVD_W-1:0]    step_size;
  logic [lir_pkg::FRAC_W-1:0]   phase_frac;
  logic [lir_pkg::IDX_W-1:0]    read_index;
  logic [lir_pkg::IDX_W-1:0]    inputs_seen;
  logic [CNT_W-1:0]             write_index;
  logic [CNT_W-1:0]             output_total;
  logic [4:0]                   burst;

  lir_pkg::div_req_t div_req;
  lir_pkg::div_rsp_t div_rsp;

  logic [lir_pkg::PERIOD_W-1:0] rp_c;
  logic [lir_pkg::PERIOD_W-1:0] np_c;
  logic [25:0]                  len_prod;
  logic [lir_pkg::WL_W-1:0]     wl;
  logic [lir_pkg::WL_W-1:0]     wl_even;
  logic [CNT_W-1:0]             total_clamp;
  logic                         pass_run;
  logic [lir_pkg::IDX_W:0]      i_ext;
  logic [lir_pkg::IDX_W:0]      rd_ext;
  logic [lir_pkg::IDX_W:0]      rd1;
  logic [lir_pkg::IDX_W:0]      rd2;
  logic                         last;
  logic                         can_emit;
  logic                         slot_free;
  logic                         out_fire;
  logic signed [7:0]            tap_a;
  logic signed [7:0]            tap_b;
  logic signed [7:0]            interp_y;
  logic [lir_pkg::DVD_W:0]      phase_acc;

  assign rp_c     = lir_pkg::clamp_period(ref_period);
  assign np_c     = lir_pkg::clamp_period(new_period);
  assign len_prod = 26'(source_length) * 26'(np_c);
  assign wl       = div_rsp.quotient[lir_pkg::WL_W-1:0];
  assign wl_even  = {wl[lir_pkg::WL_W-1:1], 1'b0};
  assign total_clamp = (wl_even > lir_pkg::WL_W'(MAX_SAMPLE_LENGTH)) ?
                       CNT_W'(MAX_SAMPLE_LENGTH) : CNT_W'(wl_even);
  assign pass_run = (source_length == '0) || (wl == lir_pkg::WL_W'(source_length)) ||
                    (wl == '0);

  assign i_ext  = {1'b0, inputs_seen};
  assign rd_ext = {1'b0, read_index};
  assign rd1    = rd_ext + 18'd1;
  assign rd2    = rd_ext + 18'd2;
  assign last   = (source_length == '0) ||
                  ((i_ext + 18'd1) >= 18'(source_length));

  assign tap_a = (rd_ext == i_ext) ? cur_sample : (rd1 == i_ext) ? prev_sample : 8'sd0;
  assign tap_b = (rd1 == i_ext) ? cur_sample : (rd2 == i_ext) ? prev_sample : 8'sd0;

  assign can_emit  = (burst < lir_pkg::BURST_CAP) && (write_index < output_total) &&
                     (last || (rd1 <= i_ext));
  assign slot_free = !m_tvalid || m_tready;
  assign out_fire  = (state == ST_EMIT) && slot_free && ((step_size == '0) || can_emit);
  assign phase_acc = {17'b0, phase_frac} + {1'b0, step_size};

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !s_tvalid;

  always_comb begin
    div_req.start    = (state == ST_START) ||
                       ((state == ST_DIV1) && div_rsp.done && !pass_run);
    div_req.dividend = (state == ST_START) ? lir_pkg::DVD_W'(len_prod) :
                       {source_length, 32'b0};
    div_req.divisor  = (state == ST_START) ? lir_pkg::WL_W'(rp_c) : wl;
  end

  lir_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lir_interp u_interp (
    .s1   (tap_a),
    .s2   (tap_b),
    .frac (phase_frac[31:16]),
    .y    (interp_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ref_period    <= 10'd428;
      new_period    <= 10'd428;
      source_length <= 16'd2;
      prev_sample   <= '0;
      step_size     <= '0;
      phase_frac    <= '0;
      read_index    <= '0;
      write_index   <= '0;
      inputs_seen   <= '0;
      output_total  <= '0;
      burst         <= '0;
      m_tvalid      <= 1'b0;
      m_tlast       <= 1'b0;
    end else begin
      if (out_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_sample <= s_tdata;
            burst      <= '0;
            if (inputs_seen == '0) begin
              read_index  <= '0;
              write_index <= '0;
              phase_frac  <= '0;
              step_size   <= '0;
              state       <= ST_START;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_START: begin
          state <= ST_DIV1;
        end
        ST_DIV1: begin
          if (div_rsp.done) begin
            output_total <= total_clamp;
            state        <= pass_run ? ST_EMIT : ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_rsp.done) begin
            step_size <= div_rsp.quotient;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (step_size == '0) begin
              m_tdata     <= cur_sample;
              m_tlast     <= last;
              prev_sample <= cur_sample;
              inputs_seen <= last ? '0 : inputs_seen + 17'd1;
              state       <= ST_IDLE;
            end else if (can_emit) begin
              m_tdata     <= interp_y;
              m_tlast     <= ((write_index + CNT_W'(1)) == output_total);
              write_index <= write_index + CNT_W'(1);
              burst       <= burst + 5'd1;
              read_index  <= read_index + phase_acc[48:32];
              phase_frac  <= phase_acc[31:0];
            end else begin
              prev_sample <= cur_sample;
              inputs_seen <= last ? '0 : inputs_seen + 17'd1;
              state       <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        unique case (lir_pkg::reg_index_t'(cfg_index))
          lir_pkg::REG_REF_PERIOD: begin
            ref_period  <= cfg_data[lir_pkg::PERIOD_W-1:0];
            inputs_seen <= '0;
          end
          lir_pkg::REG_NEW_PERIOD: begin
            new_period  <= cfg_data[lir_pkg::PERIOD_W-1:0];
            inputs_seen <= '0;
          end
          lir_pkg::REG_SOURCE_LENGTH: begin
            source_length <= cfg_data;
            inputs_seen   <= '0;
          end
          lir_pkg::REG_UNUSED: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/lir_checker.sv
// Port-level checks for the resampler, bound to the top level.
module lir_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output request changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted request");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
